// ===== hw/rtl/wpf_pkg.sv =====
// Shared types and constants of the waypoint path follower.
// Used by every module of the block; depends on nothing.
`default_nettype none

package wpf_pkg;

    // One 3-D point, element 0 is x in the lowest bits
    typedef logic [2:0][31:0] vec3_t;

    localparam int MAX_WAYPOINTS_DEF = 64;

    // Configuration port
    localparam int APB_AW = 4;
    localparam logic [1:0] REG_TOL   = 2'd0;
    localparam logic [1:0] REG_SPEED = 2'd1;
    localparam logic [1:0] REG_STEER = 2'd2;

    localparam logic [31:0] TOL_DEFAULT   = 32'd16384;
    localparam logic [31:0] SPEED_DEFAULT = 32'd196608;

    // Request kinds
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    // Result status
    localparam logic [1:0] ST_RUN     = 2'd0;
    localparam logic [1:0] ST_SUCCESS = 2'd1;
    localparam logic [1:0] ST_FAIL    = 2'd2;

    // Arithmetic widths
    localparam int MAG_W  = 33;
    localparam int PROD_W = 66;
    localparam int ROOT_W = 33;
    localparam int FRAC_W = 30;

    localparam int IN_W   = 216;
    localparam int OUT_W  = 224;

endpackage

`default_nettype wire

// ===== hw/rtl/wpf_mul.sv =====
// Shared registered multiplier of the waypoint path follower.
// Depends on wpf_pkg for the operand and product widths.
`default_nettype none

module wpf_mul
    import wpf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [MAG_W-1:0]  a,
    input  wire logic [MAG_W-1:0]  b,
    output logic      [PROD_W-1:0] p
);

    logic [PROD_W-1:0] p_reg;
    logic [PROD_W-1:0] p_next;

    assign p_next = a * b;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/wpf_sqrt.sv =====
// Bit-serial floor square root, one root bit per cycle.
// Depends on wpf_pkg for the radicand and root widths.
`default_nettype none

module wpf_sqrt
    import wpf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] rad,
    output logic                   done,
    output logic      [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [PROD_W-1:0] rad_reg,  rad_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;

    assign rem_sh = {rem_reg, rad_reg[PROD_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = rad;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[PROD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/wpf_div.sv =====
// Restoring divider for the step fraction (num << 30) / den, num < den.
// One quotient bit per cycle; depends on wpf_pkg for widths.
`default_nettype none

module wpf_div
    import wpf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [ROOT_W-1:0] num,
    input  wire logic [ROOT_W-1:0] den,
    output logic                   done,
    output logic      [FRAC_W-1:0] quo
);

    localparam int CNT_W = $clog2(FRAC_W);

    logic [ROOT_W-1:0] r_reg,    r_next;
    logic [ROOT_W-1:0] den_reg,  den_next;
    logic [FRAC_W-1:0] q_reg,    q_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [ROOT_W:0]   r_sh;

    assign r_sh = {r_reg, 1'b0};

    always_comb
    begin
        r_next    = r_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            r_next    = num;
            den_next  = den;
            q_next    = '0;
            cnt_next  = CNT_W'(FRAC_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (r_sh >= {1'b0, den_reg})
            begin
                r_next = ROOT_W'(r_sh - {1'b0, den_reg});
                q_next = {q_reg[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                r_next = r_sh[ROOT_W-1:0];
                q_next = {q_reg[FRAC_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/waypoint_path_follower_core.sv =====
// Top level of the waypoint path follower: sequencer, path memory, registers.
// Depends on wpf_pkg, wpf_mul, wpf_sqrt and wpf_div.
`default_nettype none

// Waypoint path follower. Clear and append requests load a path of up to
// MAX_WAYPOINTS points into an on-chip memory and answer with a result.
// A tick request walks the path with one shared multiplier, a bit-serial
// square-root unit and a bit-serial divider, one request at a time; s_tready
// is low while a tick is in work. A tick reads and checks each waypoint
// skipped as reached, and measures each remaining path segment, the leg to
// the current waypoint included, in the square-root unit, one root bit per
// cycle. When steering is on it stops at the waypoint if the step reaches
// it, else it runs the divider and then the per-axis step. Accept,
// tolerance squaring, result setup and output wrap these steps. The result
// waits in an output register, so the next request is taken while it is
// still pending.
module waypoint_path_follower_core
    import wpf_pkg::*;
#(
    parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // point_x, point_y, point_z, pos_x, pos_y, pos_z, delta_time
    input  wire logic [IN_W-1:0]   s_tdata,
    // mode
    input  wire logic [1:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // target_x, target_y, target_z, remaining_length, next_x, next_y, next_z
    output logic      [OUT_W-1:0]  m_tdata,
    // status, moved
    output logic      [2:0]        m_tuser,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TOL   = 4'd1;
    localparam logic [3:0] S_TOLW  = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_SQRT  = 4'd6;
    localparam logic [3:0] S_STEER = 4'd7;
    localparam logic [3:0] S_TRV   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_STEP  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    function automatic logic [1:0] axis_clip(input logic [1:0] a);
        return (a == 2'd3) ? 2'd0 : a;
    endfunction

    // Configuration registers
    logic [31:0] tol_reg;
    logic [31:0] speed_reg;
    logic        steer_reg;
    logic        cfg_wr;

    // Sequencer state
    logic [3:0]        state_reg,      state_next;
    logic [CW-1:0]     count_reg,      count_next;
    logic [CW-1:0]     cur_reg,        cur_next;
    logic [CW-1:0]     idx_reg,        idx_next;
    logic              seg_reg,        seg_next;
    logic [1:0]        ax_reg,         ax_next;
    vec3_t             pos_reg,        pos_next;
    logic [23:0]       dt_reg,         dt_next;
    vec3_t             w_reg,          w_next;
    vec3_t             prev_reg,       prev_next;
    logic [PROD_W-1:0] acc_reg,        acc_next;
    logic [63:0]       tolsq_reg,      tolsq_next;
    logic [ROOT_W-1:0] dist_reg,       dist_next;
    logic [31:0]       rem_reg,        rem_next;
    logic [FRAC_W-1:0] f_reg,          f_next;
    logic [1:0]        res_status_reg, res_status_next;
    vec3_t             res_t_reg,      res_t_next;
    logic [31:0]       res_rem_reg,    res_rem_next;
    vec3_t             res_n_reg,      res_n_next;
    logic              res_moved_reg,  res_moved_next;
    logic              m_tvalid_reg,   m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg,    m_tdata_next;
    logic [2:0]        m_tuser_reg,    m_tuser_next;

    // Path memory
    vec3_t mem [MAX_WAYPOINTS];
    vec3_t rd_reg;
    logic  mem_we;
    logic  mem_rd;

    // Datapath
    logic [MAG_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    logic              sqrt_start, sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;
    logic              div_start, div_done;
    logic [FRAC_W-1:0] div_quo;

    logic [31:0]       tol_eff, speed_eff;
    logic [1:0]        ka, kf;
    logic [31:0]       op_a, op_b;
    logic [MAG_W-1:0]  diff, dmag;
    logic [MAG_W-1:0]  fdiff;
    logic [MAG_W:0]    step_pk, step_nv;
    logic [CW-1:0]     idx_inc;
    logic [33:0]       rem_sum;
    logic [31:0]       rem_sat;
    logic [39:0]       travel;
    vec3_t             s_point, s_pos;

    assign s_point = s_tdata[95:0];
    assign s_pos   = s_tdata[191:96];

    assign tol_eff   = (tol_reg == '0)   ? TOL_DEFAULT   : tol_reg;
    assign speed_eff = (speed_reg == '0) ? SPEED_DEFAULT : speed_reg;

    // Axis launched into the multiplier, and axis whose product lands now
    assign ka = axis_clip(ax_reg);
    assign kf = axis_clip(ax_reg - 2'd1);

    always_comb
    begin
        if (state_reg == S_STEP)
        begin
            op_a = w_reg[ka];
            op_b = pos_reg[ka];
        end
        else if (seg_reg)
        begin
            op_a = rd_reg[ka];
            op_b = prev_reg[ka];
        end
        else
        begin
            op_a = pos_reg[ka];
            op_b = rd_reg[ka];
        end
    end

    assign diff  = {op_a[31], op_a} - {op_b[31], op_b};
    assign dmag  = diff[MAG_W-1] ? MAG_W'(-diff) : diff;
    assign fdiff = {w_reg[kf][31], w_reg[kf]} - {pos_reg[kf][31], pos_reg[kf]};

    assign step_pk = {pos_reg[kf][31], pos_reg[kf][31], pos_reg[kf]};
    assign step_nv = fdiff[MAG_W-1] ? step_pk - {1'b0, mul_p[62:30]}
                                    : step_pk + {1'b0, mul_p[62:30]};

    assign idx_inc = idx_reg + 1'b1;
    assign rem_sum = (seg_reg ? {2'b00, rem_reg} : 34'd0) + {1'b0, sqrt_root};
    assign rem_sat = (rem_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : rem_sum[31:0];
    assign travel  = mul_p[55:16];

    always_comb
    begin
        unique case (state_reg)
            S_TOL:
            begin
                mul_a = {1'b0, tol_eff};
                mul_b = {1'b0, tol_eff};
            end
            S_SQ:
            begin
                mul_a = dmag;
                mul_b = dmag;
            end
            S_STEER:
            begin
                mul_a = {1'b0, speed_eff};
                mul_b = {9'd0, dt_reg};
            end
            S_STEP:
            begin
                mul_a = dmag;
                mul_b = {3'd0, f_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    wpf_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    wpf_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (acc_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    wpf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (travel[ROOT_W-1:0]),
        .den   (dist_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        idx_next        = idx_reg;
        seg_next        = seg_reg;
        ax_next         = ax_reg;
        pos_next        = pos_reg;
        dt_next         = dt_reg;
        w_next          = w_reg;
        prev_next       = prev_reg;
        acc_next        = acc_reg;
        tolsq_next      = tolsq_reg;
        dist_next       = dist_reg;
        rem_next        = rem_reg;
        f_next          = f_reg;
        res_status_next = res_status_reg;
        res_t_next      = res_t_reg;
        res_rem_next    = res_rem_reg;
        res_n_next      = res_n_reg;
        res_moved_next  = res_moved_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        mem_we          = 1'b0;
        mem_rd          = 1'b0;
        sqrt_start      = 1'b0;
        div_start       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_status_next = ST_RUN;
                    res_t_next      = '0;
                    res_rem_next    = '0;
                    res_n_next      = '0;
                    res_moved_next  = 1'b0;
                    state_next      = S_OUT;
                    unique case (s_tuser)
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                            cur_next   = '0;
                        end
                        MODE_APPEND:
                        begin
                            if (count_reg < CW'(MAX_WAYPOINTS))
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_TICK:
                        begin
                            pos_next   = s_pos;
                            dt_next    = s_tdata[215:192];
                            res_n_next = s_pos;
                            idx_next   = cur_reg;
                            seg_next   = 1'b0;
                            if (count_reg == '0)
                                res_status_next = ST_FAIL;
                            else
                                state_next = S_TOL;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_TOL:
            begin
                state_next = S_TOLW;
            end
            S_TOLW:
            begin
                tolsq_next = mul_p[63:0];
                if (idx_reg >= count_reg)
                begin
                    res_status_next = ST_SUCCESS;
                    res_t_next      = pos_reg;
                    state_next      = S_OUT;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                mem_rd     = 1'b1;
                acc_next   = '0;
                ax_next    = '0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                // launch one axis a cycle, sum the product of the one before
                if (ax_reg != 2'd0)
                    acc_next = acc_reg + mul_p;
                ax_next = ax_reg + 2'd1;
                if (ax_reg == 2'd3)
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                if (!seg_reg && (acc_reg <= {2'b00, tolsq_reg}))
                begin
                    if (idx_inc >= count_reg)
                    begin
                        cur_next        = count_reg;
                        res_status_next = ST_SUCCESS;
                        res_t_next      = pos_reg;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    if (!seg_reg)
                    begin
                        cur_next = idx_reg;
                        w_next   = rd_reg;
                    end
                    sqrt_start = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    if (!seg_reg)
                        dist_next = sqrt_root;
                    rem_next  = rem_sat;
                    prev_next = rd_reg;
                    if (idx_inc < count_reg)
                    begin
                        idx_next   = idx_inc;
                        seg_next   = 1'b1;
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_STEER;
                    end
                end
            end
            S_STEER:
            begin
                res_status_next = ST_RUN;
                res_t_next      = w_reg;
                res_rem_next    = rem_reg;
                state_next      = steer_reg ? S_TRV : S_OUT;
            end
            S_TRV:
            begin
                res_moved_next = 1'b1;
                if ((travel >= {7'd0, dist_reg}) || (dist_reg == '0))
                begin
                    res_n_next = w_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    f_next     = div_quo;
                    ax_next    = '0;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (ax_reg != 2'd0)
                    res_n_next[kf] = step_nv[31:0];
                ax_next = ax_reg + 2'd1;
                if (ax_reg == 2'd3)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_n_reg, res_rem_reg, res_t_reg};
                    m_tuser_next  = {res_moved_reg, res_status_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cur_reg      <= '0;
            idx_reg      <= '0;
            seg_reg      <= 1'b0;
            ax_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cur_reg      <= cur_next;
            idx_reg      <= idx_next;
            seg_reg      <= seg_next;
            ax_reg       <= ax_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        dt_reg         <= dt_next;
        w_reg          <= w_next;
        prev_reg       <= prev_next;
        acc_reg        <= acc_next;
        tolsq_reg      <= tolsq_next;
        dist_reg       <= dist_next;
        rem_reg        <= rem_next;
        f_reg          <= f_next;
        res_status_reg <= res_status_next;
        res_t_reg      <= res_t_next;
        res_rem_reg    <= res_rem_next;
        res_n_reg      <= res_n_next;
        res_moved_reg  <= res_moved_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[count_reg[AW-1:0]] <= s_point;
        if (mem_rd)
            rd_reg <= mem[idx_reg[AW-1:0]];
    end

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= TOL_DEFAULT;
            speed_reg <= SPEED_DEFAULT;
            steer_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_TOL:   tol_reg   <= pwdata;
                REG_SPEED: speed_reg <= pwdata;
                REG_STEER: steer_reg <= pwdata[0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TOL:   prdata = tol_reg;
            REG_SPEED: prdata = speed_reg;
            REG_STEER: prdata = {31'd0, steer_reg};
            default:   prdata = '0;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/wpf_chk.sv =====
// Port-level checker of the waypoint path follower, bound to the top level.
// Depends on wpf_pkg for status codes and widths.
`default_nettype none

module wpf_chk
    import wpf_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [OUT_W-1:0]  m_tdata,
    input wire logic [2:0]        m_tuser
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // One request at a time: busy right after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // Failure carries no length and no move
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] == ST_FAIL) |-> !m_tuser[2] && (m_tdata[127:96] == '0))
        else $error("failure result with length or move");

    // Success reports the position as target and as next
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] == ST_SUCCESS)
        |-> !m_tuser[2] && (m_tdata[127:96] == '0) && (m_tdata[95:0] == m_tdata[223:128]))
        else $error("success result inconsistent");

    // No status code beyond failure
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[1:0] == ST_RUN) || (m_tuser[1:0] == ST_SUCCESS)
                     || (m_tuser[1:0] == ST_FAIL))
        else $error("bad status code");

endmodule

bind waypoint_path_follower_core wpf_chk u_wpf_chk (.*);

`default_nettype wire
